/* src/fdt_pkg.sv */
// Shared types for the tick-count to FAT date/time converter.
// Packed layouts of the DOS date and time words; no dependencies.
package fdt_pkg;

    localparam int DAYS_W   = 16;
    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SEC2_W   = 5;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } dos_date_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SEC2_W-1:0]   sec2;
    } dos_time_t;

endpackage

/* src/fdt_pipe_reg.sv */
// One valid/ready pipeline register stage with bubble fill.
// Generic; no package dependencies.
module fdt_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* src/fdt_cdiv.sv */
// Two-stage divider by a constant: reciprocal multiply, then remainder.
// Uses fdt_pipe_reg; sideband bits travel alongside the operand.
module fdt_cdiv #(
    parameter int A_W     = 16,
    parameter int DIVISOR = 3,
    parameter int Q_W     = 15,
    parameter int R_W     = 2,
    parameter int SIDE_W  = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [A_W-1:0]    in_a,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [Q_W-1:0]    out_q,
    output logic [R_W-1:0]    out_r,
    output logic [SIDE_W-1:0] out_side
);

    localparam int K = A_W + $clog2(DIVISOR);
    localparam int M_W = A_W + 2;
    localparam int P_W = A_W + M_W;
    localparam logic [63:0] MAGIC_WIDE =
        ((64'd1 << K) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [M_W-1:0] MAGIC = MAGIC_WIDE[M_W-1:0];
    localparam logic [A_W-1:0] DIV_A = A_W'(DIVISOR);
    localparam int S1_W = SIDE_W + A_W + Q_W;
    localparam int S2_W = SIDE_W + Q_W + R_W;

    logic [P_W-1:0]    prod;
    logic [Q_W-1:0]    q_est;
    logic              s1_valid;
    logic              s1_ready;
    logic [S1_W-1:0]   s1_data;
    logic [SIDE_W-1:0] s1_side;
    logic [A_W-1:0]    s1_a;
    logic [Q_W-1:0]    s1_q;
    logic [A_W-1:0]    rem_full;
    logic [S2_W-1:0]   s2_data;

    assign prod  = {{M_W{1'b0}}, in_a} * {{A_W{1'b0}}, MAGIC};
    assign q_est = prod[K +: Q_W];

    fdt_pipe_reg #(.WIDTH(S1_W)) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   ({in_side, in_a, q_est}),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    assign {s1_side, s1_a, s1_q} = s1_data;
    assign rem_full = s1_a - A_W'(s1_q) * DIV_A;

    fdt_pipe_reg #(.WIDTH(S2_W)) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   ({s1_side, s1_q, rem_full[R_W-1:0]}),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (s2_data)
    );

    assign {out_side, out_q, out_r} = s2_data;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (
        @(posedge aclk) disable iff (!aresetn)
        out_valid |-> (A_W'(out_r) < DIV_A)
    ) else $error("remainder not below divisor");
`endif

endmodule

/* src/fdt_civil.sv */
// Day count since 1970-01-01 to Gregorian year, month and day.
// Uses fdt_pkg, fdt_pipe_reg and fdt_cdiv; sideband bits pass through.
module fdt_civil
    import fdt_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DAYS_W-1:0] in_days,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output dos_date_t         out_date,
    output logic [SIDE_W-1:0] out_side
);

    localparam int DOE_W = 18;
    localparam int Z_W   = 20;
    localparam int C0_W  = SIDE_W + 1 + DOE_W;
    localparam int C1_W  = SIDE_W + 1 + 7 + 2 + DOE_W;
    localparam int D8S_W = SIDE_W + 1 + 7 + 2;
    localparam int C2_W  = SIDE_W + 1 + 9 + 9;
    localparam int D9S_W = SIDE_W + 1 + 9;
    localparam int D10S_W = SIDE_W + YEAR_W + MONTH_W;

    logic [Z_W-1:0]     z;
    logic               era5_in;
    logic [DOE_W-1:0]   doe_in;

    logic               c0_valid, c0_ready;
    logic [C0_W-1:0]    c0_data;
    logic [DOE_W-1:0]   c0_doe;

    logic               d7_valid, d7_ready;
    logic [6:0]         d7_q;
    logic [C0_W-1:0]    d7_side;
    logic [SIDE_W-1:0]  d7_ext;
    logic               d7_era5;
    logic [DOE_W-1:0]   d7_doe;
    logic [2:0]         cent_cnt;
    logic [1:0]         ccent;
    logic [DOE_W-1:0]   t_in;

    logic               c1_valid, c1_ready;
    logic [C1_W-1:0]    c1_data;
    logic [D8S_W-1:0]   c1_side;
    logic [DOE_W-1:0]   c1_t;

    logic               d8_valid, d8_ready;
    logic [8:0]         d8_yoe;
    logic [8:0]         d8_r;
    logic [D8S_W-1:0]   d8_side;
    logic [SIDE_W-1:0]  d8_ext;
    logic               d8_era5;
    logic [6:0]         d8_q7;
    logic [1:0]         d8_ccent;
    logic [1:0]         c100;
    logic [8:0]         doy_in;

    logic               c2_valid, c2_ready;
    logic [C2_W-1:0]    c2_data;
    logic [D9S_W-1:0]   c2_side;
    logic [8:0]         c2_doy;

    logic               d9_valid, d9_ready;
    logic [3:0]         d9_mp;
    logic [7:0]         d9_r;
    logic [D9S_W-1:0]   d9_side;
    logic [SIDE_W-1:0]  d9_ext;
    logic               d9_era5;
    logic [8:0]         d9_yoe;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year7;

    logic [DAY_W-1:0]   d10_q;
    logic [D10S_W-1:0]  d10_side;

    // shift epoch to 0000-03-01; era is 4 or 5 for any 16-bit day count
    assign z       = Z_W'(in_days) + 20'd719468;
    assign era5_in = (z >= 20'd730485);
    assign doe_in  = era5_in ? DOE_W'(z - 20'd730485) : DOE_W'(z - 20'd584388);

    fdt_pipe_reg #(.WIDTH(C0_W)) u_c0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   ({in_side, era5_in, doe_in}),
        .out_valid (c0_valid),
        .out_ready (c0_ready),
        .out_data  (c0_data)
    );

    assign c0_doe = c0_data[DOE_W-1:0];

    fdt_cdiv #(.A_W(16), .DIVISOR(365), .Q_W(7), .R_W(9), .SIDE_W(C0_W)) u_d1460 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c0_valid),
        .in_ready  (c0_ready),
        .in_a      (c0_doe[DOE_W-1:2]),
        .in_side   (c0_data),
        .out_valid (d7_valid),
        .out_ready (d7_ready),
        .out_q     (d7_q),
        .out_r     (),
        .out_side  (d7_side)
    );

    assign {d7_ext, d7_era5, d7_doe} = d7_side;
    assign cent_cnt = 3'(d7_doe >= 18'd36524) + 3'(d7_doe >= 18'd73048)
                    + 3'(d7_doe >= 18'd109572) + 3'(d7_doe >= 18'd146096)
                    - 3'(d7_doe == 18'd146096);
    assign ccent = cent_cnt[1:0];
    assign t_in  = d7_doe - DOE_W'(d7_q) + DOE_W'(ccent);

    fdt_pipe_reg #(.WIDTH(C1_W)) u_c1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d7_valid),
        .in_ready  (d7_ready),
        .in_data   ({d7_ext, d7_era5, d7_q, ccent, t_in}),
        .out_valid (c1_valid),
        .out_ready (c1_ready),
        .out_data  (c1_data)
    );

    assign {c1_side, c1_t} = c1_data;

    fdt_cdiv #(.A_W(DOE_W), .DIVISOR(365), .Q_W(9), .R_W(9), .SIDE_W(D8S_W)) u_dyear (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c1_valid),
        .in_ready  (c1_ready),
        .in_a      (c1_t),
        .in_side   (c1_side),
        .out_valid (d8_valid),
        .out_ready (d8_ready),
        .out_q     (d8_yoe),
        .out_r     (d8_r),
        .out_side  (d8_side)
    );

    assign {d8_ext, d8_era5, d8_q7, d8_ccent} = d8_side;
    assign c100 = 2'(d8_yoe >= 9'd100) + 2'(d8_yoe >= 9'd200) + 2'(d8_yoe >= 9'd300);
    assign doy_in = d8_r + 9'(d8_q7) - 9'(d8_ccent) - 9'(d8_yoe[8:2]) + 9'(c100);

    fdt_pipe_reg #(.WIDTH(C2_W)) u_c2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d8_valid),
        .in_ready  (d8_ready),
        .in_data   ({d8_ext, d8_era5, d8_yoe, doy_in}),
        .out_valid (c2_valid),
        .out_ready (c2_ready),
        .out_data  (c2_data)
    );

    assign {c2_side, c2_doy} = c2_data;

    fdt_cdiv #(.A_W(11), .DIVISOR(153), .Q_W(4), .R_W(8), .SIDE_W(D9S_W)) u_dmonth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c2_valid),
        .in_ready  (c2_ready),
        .in_a      (11'(c2_doy) * 11'd5 + 11'd2),
        .in_side   (c2_side),
        .out_valid (d9_valid),
        .out_ready (d9_ready),
        .out_q     (d9_mp),
        .out_r     (d9_r),
        .out_side  (d9_side)
    );

    assign {d9_ext, d9_era5, d9_yoe} = d9_side;
    assign month = (d9_mp < 4'd10) ? d9_mp + 4'd3 : d9_mp - 4'd9;
    // year - 1980 mod 128: era offset is 20 for era 5 and 4 for era 4
    assign year7 = d9_yoe[YEAR_W-1:0] + (d9_era5 ? 7'd20 : 7'd4)
                 + YEAR_W'(month <= 4'd2);

    fdt_cdiv #(.A_W(8), .DIVISOR(5), .Q_W(DAY_W), .R_W(3), .SIDE_W(D10S_W)) u_dday (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d9_valid),
        .in_ready  (d9_ready),
        .in_a      (d9_r),
        .in_side   ({d9_ext, year7, month}),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_q     (d10_q),
        .out_r     (),
        .out_side  (d10_side)
    );

    assign out_side       = d10_side[D10S_W-1 -: SIDE_W];
    assign out_date.year  = d10_side[YEAR_W+MONTH_W-1 -: YEAR_W];
    assign out_date.month = d10_side[MONTH_W-1:0];
    assign out_date.day   = d10_q + 5'd1;

`ifndef SYNTHESIS
    a_doe_in_era: assert property (
        @(posedge aclk) disable iff (!aresetn)
        c0_valid |-> (c0_doe < 18'd146097)
    ) else $error("day of era out of range");
`endif

endmodule

/* src/file_time_to_dos_date_time.sv */
// Tick count (100 ns since 1601) to FAT date and time words, top level.
// Uses fdt_pkg, fdt_pipe_reg, fdt_cdiv and fdt_civil.

// Each transfer on s_tick_count yields one transfer on the m_ side after 25
// register stages, one item per cycle while m_ready is high. The chain is a
// range check and epoch subtract, three long-division steps of 12 bits
// that divide by 10^7, constant dividers for days, hours and minutes, and
// the calendar stages; every divider is a reciprocal multiply followed by
// a remainder stage. Bubbles are squeezed out, so input keeps flowing while
// a result waits until the pipeline is full. Counts below 1970-01-01 or
// past the 32-bit second range give m_valid_res = 0 with both words zero.
module file_time_to_dos_date_time
    import fdt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_tick_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_dos_date,
    output logic [15:0] m_dos_time,
    output logic        m_valid_res
);

    localparam logic [63:0] TICK_LO  = 64'd116444736000000000;
    localparam logic [63:0] TICK_END = 64'd159394408960000000;

    logic [63:0]  ofs;
    logic         in_range;

    logic         f_valid, f_ready;
    logic [49:0]  f_data;
    logic         f_ok;
    logic [48:0]  f_y;

    logic         d1_valid, d1_ready;
    logic [11:0]  d1_q;
    logic [16:0]  d1_r;
    logic [24:0]  d1_side;

    logic         d2_valid, d2_ready;
    logic [11:0]  d2_q;
    logic [16:0]  d2_r;
    logic [24:0]  d2_side;

    logic         d3_valid, d3_ready;
    logic [11:0]  d3_q;
    logic [24:0]  d3_side;
    logic [31:0]  secs;

    logic         d4_valid, d4_ready;
    logic [15:0]  d4_q;
    logic [9:0]   d4_r;
    logic [7:0]   d4_side;
    logic [16:0]  rem_day;

    logic         d5_valid, d5_ready;
    logic [4:0]   d5_q;
    logic [7:0]   d5_r;
    logic [20:0]  d5_side;
    logic [11:0]  rem_hour;

    logic         d6_valid, d6_ready;
    logic [5:0]   d6_q;
    logic [3:0]   d6_r;
    logic [22:0]  d6_side;
    dos_time_t    dtime;

    logic         cv_valid, cv_ready;
    dos_date_t    cv_date;
    logic [16:0]  cv_side;
    logic         cv_ok;
    logic [32:0]  out_word;
    logic [32:0]  o_data;

    assign in_range = (s_tick_count >= TICK_LO) && (s_tick_count < TICK_END);
    assign ofs      = s_tick_count - TICK_LO;

    // divide by 128 here, the remaining 78125 in the long-division steps
    fdt_pipe_reg #(.WIDTH(50)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   ({in_range, ofs[55:7]}),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    assign {f_ok, f_y} = f_data;

    fdt_cdiv #(.A_W(29), .DIVISOR(78125), .Q_W(12), .R_W(17), .SIDE_W(25)) u_dsec1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_a      ({4'd0, f_y[48:24]}),
        .in_side   ({f_ok, f_y[23:0]}),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_q     (d1_q),
        .out_r     (d1_r),
        .out_side  (d1_side)
    );

    fdt_cdiv #(.A_W(29), .DIVISOR(78125), .Q_W(12), .R_W(17), .SIDE_W(25)) u_dsec2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_a      ({d1_r, d1_side[23:12]}),
        .in_side   ({d1_side[24], d1_q, d1_side[11:0]}),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .out_q     (d2_q),
        .out_r     (d2_r),
        .out_side  (d2_side)
    );

    fdt_cdiv #(.A_W(29), .DIVISOR(78125), .Q_W(12), .R_W(17), .SIDE_W(25)) u_dsec3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d2_valid),
        .in_ready  (d2_ready),
        .in_a      ({d2_r, d2_side[11:0]}),
        .in_side   ({d2_side[24], d2_side[23:12], d2_q}),
        .out_valid (d3_valid),
        .out_ready (d3_ready),
        .out_q     (d3_q),
        .out_r     (),
        .out_side  (d3_side)
    );

    assign secs = {d3_side[19:12], d3_side[11:0], d3_q};

    // divide by 86400 as 128 * 675
    fdt_cdiv #(.A_W(25), .DIVISOR(675), .Q_W(DAYS_W), .R_W(10), .SIDE_W(8)) u_dday (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d3_valid),
        .in_ready  (d3_ready),
        .in_a      (secs[31:7]),
        .in_side   ({d3_side[24], secs[6:0]}),
        .out_valid (d4_valid),
        .out_ready (d4_ready),
        .out_q     (d4_q),
        .out_r     (d4_r),
        .out_side  (d4_side)
    );

    assign rem_day = {d4_r, d4_side[6:0]};

    // divide by 3600 as 16 * 225
    fdt_cdiv #(.A_W(13), .DIVISOR(225), .Q_W(HOUR_W), .R_W(8), .SIDE_W(21)) u_dhour (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d4_valid),
        .in_ready  (d4_ready),
        .in_a      (rem_day[16:4]),
        .in_side   ({d4_side[7], d4_q, rem_day[3:0]}),
        .out_valid (d5_valid),
        .out_ready (d5_ready),
        .out_q     (d5_q),
        .out_r     (d5_r),
        .out_side  (d5_side)
    );

    assign rem_hour = {d5_r, d5_side[3:0]};

    // divide by 60 as 4 * 15
    fdt_cdiv #(.A_W(10), .DIVISOR(15), .Q_W(MINUTE_W), .R_W(4), .SIDE_W(23)) u_dmin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d5_valid),
        .in_ready  (d5_ready),
        .in_a      (rem_hour[11:2]),
        .in_side   ({d5_side[20:4], d5_q, rem_hour[1]}),
        .out_valid (d6_valid),
        .out_ready (d6_ready),
        .out_q     (d6_q),
        .out_r     (d6_r),
        .out_side  (d6_side)
    );

    assign dtime.hour   = d6_side[5:1];
    assign dtime.minute = d6_q;
    assign dtime.sec2   = {d6_r, d6_side[0]};

    fdt_civil #(.SIDE_W(17)) u_civil (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d6_valid),
        .in_ready  (d6_ready),
        .in_days   (d6_side[21:6]),
        .in_side   ({d6_side[22], dtime}),
        .out_valid (cv_valid),
        .out_ready (cv_ready),
        .out_date  (cv_date),
        .out_side  (cv_side)
    );

    assign cv_ok    = cv_side[16];
    assign out_word = cv_ok ? {1'b1, cv_date, cv_side[15:0]} : 33'd0;

    fdt_pipe_reg #(.WIDTH(33)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cv_valid),
        .in_ready  (cv_ready),
        .in_data   (out_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (o_data)
    );

    assign {m_valid_res, m_dos_date, m_dos_time} = o_data;

`ifndef SYNTHESIS
    a_date_fields_legal: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |->
            (m_dos_date[8:5] >= 4'd1) && (m_dos_date[8:5] <= 4'd12) &&
            (m_dos_date[4:0] >= 5'd1)
    ) else $error("month or day out of range");

    a_time_fields_legal: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |->
            (m_dos_time[15:11] <= 5'd23) && (m_dos_time[10:5] <= 6'd59) &&
            (m_dos_time[4:0] <= 5'd29)
    ) else $error("hour, minute or second out of range");

    a_stall_only_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready)
    ) else $error("input held off while output not stalled");
`endif

endmodule
